@@ src/opa_pkg.sv @@
// ----------------------------------------------------------------------------
// OKLab pixel adjuster package
// Shared widths, matrix coefficients, mode and register codes, and the sRGB
// decode and encode tables, which are built at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opa_pkg;

	localparam int CW       = 20;  // matrix coefficient width, signed Q.16
	localparam int LIN_W    = 17;  // linear and LMS values, Q0.16, 0..65536
	localparam int LAB_W    = 20;  // Lab values straight out of the forward matrix
	localparam int LABC_W   = 18;  // Lab values after the Q2.16 saturation
	localparam int FAC_W    = 16;  // factor, signed Q2.14
	localparam int CH_W     = 8;   // one sRGB channel
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Cube root: bits of the root resolved per pipeline stage.
	localparam int CBRT_BPS  = 2;
	localparam int CBRT_LAT  = (LIN_W + CBRT_BPS - 1) / CBRT_BPS + 1;
	localparam int TOLAB_LAT = 3 + CBRT_LAT + 2;
	localparam int ADJ_LAT   = 3;
	localparam int TORGB_LAT = 10;
	localparam int PIPE_LAT  = TOLAB_LAT + ADJ_LAT + TORGB_LAT;

	typedef logic signed [CW-1:0] coef_t;
	typedef coef_t mat_t [3][3];

	localparam mat_t FWD_LMS = '{
		'{20'sd27015, 20'sd35149, 20'sd3372},
		'{20'sd13887, 20'sd44610, 20'sd7039},
		'{20'sd5787, 20'sd18463, 20'sd41286}};
	localparam mat_t FWD_LAB = '{
		'{20'sd13792, 20'sd52011, -20'sd267},
		'{20'sd129630, -20'sd159160, 20'sd29530},
		'{20'sd1698, 20'sd51300, -20'sd52998}};
	localparam mat_t INV_LMS = '{
		'{20'sd65536, 20'sd25974, 20'sd14143},
		'{20'sd65536, -20'sd6918, -20'sd4185},
		'{20'sd65536, -20'sd5864, -20'sd84639}};
	localparam mat_t INV_RGB = '{
		'{20'sd267173, -20'sd216774, 20'sd15137},
		'{-20'sd83128, 20'sd171033, -20'sd22369},
		'{-20'sd275, -20'sd46099, 20'sd111910}};

	typedef enum logic [2:0] {
		MODE_LIGHTER = 3'd0,
		MODE_DARKER  = 3'd1,
		MODE_SCALE   = 3'd2,
		MODE_TINT    = 3'd3,
		MODE_SAT     = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE       = 3'd0,
		CFG_FACTOR     = 3'd1,
		CFG_TINT_RED   = 3'd2,
		CFG_TINT_GREEN = 3'd3,
		CFG_TINT_BLUE  = 3'd4
	} cfg_idx_t;

	typedef logic [LIN_W-1:0] tab_t [256];

	// Fifth power in Q24 with truncating multiplies.
	function automatic longint unsigned pow5_q24(input longint unsigned r);
		longint unsigned p;
		p = (r * r) >> 24;
		p = (p * r) >> 24;
		p = (p * r) >> 24;
		return (p * r) >> 24;
	endfunction

	// One entry of the sRGB decode curve, linear light in Q0.16.
	function automatic logic [LIN_W-1:0] dec_entry(input int unsigned c);
		longint unsigned cc, t, lo, hi, mid, u, l24;
		cc = 64'(c);
		lo = 64'd0;
		hi = 64'd1 << 24;
		if (c <= 10)
			return LIN_W'((cc * 64'd6553600 + 64'd164730) / 64'd329460);
		t = ((cc * 64'd1000 + 64'd14025) << 24) / 64'd269025;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			if (pow5_q24(mid) <= t)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		u = (t * lo) >> 24;
		l24 = (u * u) >> 24;
		return LIN_W'((l24 + 64'd128) >> 8);
	endfunction

	function automatic tab_t build_dec();
		tab_t d;
		for (int c = 0; c < 256; c++)
			d[c] = dec_entry(c);
		return d;
	endfunction

	// Encode thresholds: midpoints between neighbouring decode entries.
	function automatic tab_t build_thr();
		tab_t d;
		tab_t t;
		d = build_dec();
		t[0] = '0;
		for (int k = 1; k < 256; k++)
			t[k] = LIN_W'((18'(d[k-1]) + 18'(d[k]) + 18'd1) >> 1);
		return t;
	endfunction

	localparam tab_t DEC_TAB = build_dec();
	localparam tab_t ENC_THR = build_thr();

endpackage

`default_nettype wire

@@ src/opa_pix_in_if.sv @@
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one sRGB pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface opa_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source(output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink(input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

`default_nettype wire

@@ src/opa_pix_out_if.sv @@
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying one adjusted sRGB pixel and its clip flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface opa_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       clipped;

	modport source(output valid, output out_red, output out_green, output out_blue,
		output clipped, input ready);
	modport sink(input valid, input out_red, input out_green, input out_blue,
		input clipped, output ready);
endinterface

`default_nettype wire

@@ src/opa_cbrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined cube root
// Round-to-nearest cube root of a Q0.16 value, two root bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opa_cbrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [opa_pkg::LIN_W-1:0] x,
	output logic [opa_pkg::LIN_W-1:0] root
);
	localparam int NB  = opa_pkg::LIN_W;
	localparam int BPS = opa_pkg::CBRT_BPS;
	localparam int NST = (NB + BPS - 1) / BPS;

	logic [NB-1:0]     x_s  [NST];
	logic [NB-1:0]     r_s  [NST];
	logic [2*NB-2:0]   r2_s [NST];
	logic [3*NB-3:0]   r3_s [NST];
	logic [NB-1:0]     root_s10;
	logic [3*NB+2:0]   lhs;
	logic [3*NB+2:0]   rhs;

	genvar k;
	for (k = 0; k < NST; k++) begin : g_st
		logic [NB-1:0]   xi, ri, rn;
		logic [2*NB-2:0] r2i, r2n;
		logic [3*NB-3:0] r3i, r3n;

		if (k == 0) begin : g_first
			assign xi  = x;
			assign ri  = '0;
			assign r2i = '0;
			assign r3i = '0;
		end else begin : g_next
			assign xi  = x_s[k-1];
			assign ri  = r_s[k-1];
			assign r2i = r2_s[k-1];
			assign r3i = r3_s[k-1];
		end

		// Try setting each root bit: (r + 2^b)^3 expanded from r, r^2 and r^3.
		always_comb begin : step
			logic [3*NB:0] t3;
			logic [3*NB:0] nn;
			int b;
			rn  = ri;
			r2n = r2i;
			r3n = r3i;
			nn  = (3*NB+1)'({xi, 32'd0});
			t3  = '0;
			b   = 0;
			for (int j = 0; j < BPS; j++) begin
				b = NB - 1 - (k * BPS + j);
				if (b >= 0) begin
					t3 = (3*NB+1)'(r3n) + (((3*NB+1)'(r2n) * 3) << b)
						+ (((3*NB+1)'(rn) * 3) << (2 * b)) + ((3*NB+1)'(1) << (3 * b));
					if (t3 <= nn) begin
						r2n = r2n + (2*NB-1)'(((3*NB+1)'(rn) << (b + 1))
							+ ((3*NB+1)'(1) << (2 * b)));
						r3n = t3[3*NB-3:0];
						rn  = rn | (NB'(1) << b);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]  <= xi;
				r_s[k]  <= rn;
				r2_s[k] <= r2n;
				r3_s[k] <= r3n;
			end
		end
	end

	// Round to nearest: add one when (2r+1)^3 <= 8 * x * 2^32.
	assign lhs = ((3*NB+3)'(r3_s[NST-1]) << 3) + (3*NB+3)'(r2_s[NST-1]) * 12
		+ (3*NB+3)'(r_s[NST-1]) * 6 + (3*NB+3)'(1);
	assign rhs = (3*NB+3)'({x_s[NST-1], 35'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			root_s10 <= r_s[NST-1] + NB'(lhs <= rhs);
		end
	end

	assign root = root_s10;
endmodule

`default_nettype wire

@@ src/opa_to_lab.sv @@
// ----------------------------------------------------------------------------
// sRGB to OKLab
// Decode table, LMS matrix, per-channel cube root, Lab matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opa_to_lab (
	input  logic                             clk,
	input  logic                             en,
	input  logic [opa_pkg::CH_W-1:0]         red,
	input  logic [opa_pkg::CH_W-1:0]         green,
	input  logic [opa_pkg::CH_W-1:0]         blue,
	output logic signed [opa_pkg::LAB_W-1:0] lab [3]
);
	localparam int PW = opa_pkg::CW + opa_pkg::LIN_W + 1;

	logic [opa_pkg::LIN_W-1:0]         lin_s1   [3];
	logic signed [PW-1:0]              lp_s2    [3][3];
	logic [opa_pkg::LIN_W-1:0]         lms_s3   [3];
	logic [opa_pkg::LIN_W-1:0]         root_s13 [3];
	logic signed [PW-1:0]              ap_s14   [3][3];
	logic signed [opa_pkg::LAB_W-1:0]  lab_s15  [3];
	logic signed [PW+1:0]              lsum     [3];
	logic signed [PW+1:0]              asum     [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = (PW+2)'(lp_s2[i][0]) + (PW+2)'(lp_s2[i][1])
				+ (PW+2)'(lp_s2[i][2]) + (PW+2)'(32768);
			asum[i] = (PW+2)'(ap_s14[i][0]) + (PW+2)'(ap_s14[i][1])
				+ (PW+2)'(ap_s14[i][2]) + (PW+2)'(32768);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= opa_pkg::DEC_TAB[red];
			lin_s1[1] <= opa_pkg::DEC_TAB[green];
			lin_s1[2] <= opa_pkg::DEC_TAB[blue];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					lp_s2[i][j]  <= opa_pkg::FWD_LMS[i][j] * $signed({1'b0, lin_s1[j]});
					ap_s14[i][j] <= opa_pkg::FWD_LAB[i][j] * $signed({1'b0, root_s13[j]});
				end
				// Rows sum to one, so the LMS value stays within 0..65536.
				lms_s3[i]  <= lsum[i][opa_pkg::LIN_W+15:16];
				lab_s15[i] <= asum[i][opa_pkg::LAB_W+15:16];
			end
		end
	end

	genvar c;
	for (c = 0; c < 3; c++) begin : g_root
		opa_cbrt u_cbrt (
			.clk  (clk),
			.en   (en),
			.x    (lms_s3[c]),
			.root (root_s13[c])
		);
	end

	assign lab = lab_s15;
endmodule

`default_nettype wire

@@ src/opa_adjust.sv @@
// ----------------------------------------------------------------------------
// Lab adjustment
// Applies the configured lightness, tint or saturation change and saturates
// the result to Q2.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opa_adjust (
	input  logic                              clk,
	input  logic                              en,
	input  opa_pkg::mode_t                    mode,
	input  logic signed [opa_pkg::FAC_W-1:0]  factor,
	input  logic signed [opa_pkg::LAB_W-1:0]  lab [3],
	input  logic signed [opa_pkg::LAB_W-1:0]  tint_a,
	input  logic signed [opa_pkg::LAB_W-1:0]  tint_b,
	output logic signed [opa_pkg::LABC_W-1:0] lab_adj [3]
);
	localparam int OW = opa_pkg::LAB_W + 1;
	localparam int MW = 18;
	localparam int PW = OW + MW;
	localparam int VW = PW - 13;

	logic signed [MW-1:0] f_ext, one, m_l, m_ab;
	logic signed [OW-1:0] op_l, op_a, op_b;
	logic signed [opa_pkg::LAB_W-1:0] base_a, base_b;
	logic lcl;

	logic signed [MW-1:0] m_l_s1, m_ab_s1;
	logic signed [OW-1:0] op_s1 [3];
	logic signed [opa_pkg::LAB_W-1:0] base_a_s1, base_b_s1;
	logic lcl_s1;

	logic signed [PW-1:0] p_s2 [3];
	logic signed [opa_pkg::LAB_W-1:0] base_s2 [3];
	logic lcl_s2;

	logic signed [VW-1:0] v [3];
	logic signed [opa_pkg::LABC_W-1:0] lab_s3 [3];

	// Every path is v = base + round(op * m / 2^14); pass-through uses m = 1.0.
	always_comb begin
		f_ext  = MW'(factor);
		one    = MW'(16384);
		m_l    = one;
		m_ab   = one;
		op_l   = OW'(lab[0]);
		op_a   = OW'(lab[1]);
		op_b   = OW'(lab[2]);
		base_a = '0;
		base_b = '0;
		lcl    = 1'b0;
		case (mode)
			opa_pkg::MODE_LIGHTER: begin
				m_l = one + f_ext;
				lcl = 1'b1;
			end
			opa_pkg::MODE_DARKER: begin
				m_l = one - f_ext;
				lcl = 1'b1;
			end
			opa_pkg::MODE_SCALE: begin
				m_l = f_ext;
				lcl = 1'b1;
			end
			opa_pkg::MODE_TINT: begin
				m_ab   = f_ext;
				op_a   = OW'(tint_a) - OW'(lab[1]);
				op_b   = OW'(tint_b) - OW'(lab[2]);
				base_a = lab[1];
				base_b = lab[2];
			end
			opa_pkg::MODE_SAT: begin
				m_ab = one - f_ext;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = VW'((p_s2[i] + PW'(8192)) >>> 14) + VW'(base_s2[i]);
			if (lcl_s2 && i == 0) begin
				if (v[i] < 0)
					v[i] = '0;
				else if (v[i] > VW'(65536))
					v[i] = VW'(65536);
			end
			if (v[i] > VW'(131071))
				v[i] = VW'(131071);
			else if (v[i] < -VW'(131072))
				v[i] = -VW'(131072);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_l_s1    <= m_l;
			m_ab_s1   <= m_ab;
			op_s1[0]  <= op_l;
			op_s1[1]  <= op_a;
			op_s1[2]  <= op_b;
			base_a_s1 <= base_a;
			base_b_s1 <= base_b;
			lcl_s1    <= lcl;

			p_s2[0]    <= op_s1[0] * m_l_s1;
			p_s2[1]    <= op_s1[1] * m_ab_s1;
			p_s2[2]    <= op_s1[2] * m_ab_s1;
			base_s2[0] <= '0;
			base_s2[1] <= base_a_s1;
			base_s2[2] <= base_b_s1;
			lcl_s2     <= lcl_s1;

			for (int i = 0; i < 3; i++)
				lab_s3[i] <= v[i][opa_pkg::LABC_W-1:0];
		end
	end

	assign lab_adj = lab_s3;
endmodule

`default_nettype wire

@@ src/opa_to_rgb.sv @@
// ----------------------------------------------------------------------------
// OKLab to sRGB
// Inverse LMS matrix, cube, RGB matrix, clip detection and table encode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opa_to_rgb (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [opa_pkg::LABC_W-1:0] lab [3],
	output logic [opa_pkg::CH_W-1:0]          red,
	output logic [opa_pkg::CH_W-1:0]          green,
	output logic [opa_pkg::CH_W-1:0]          blue,
	output logic                              clipped
);
	localparam int NW = opa_pkg::LIN_W;

	logic signed [37:0] lp_s1   [3][3];
	logic signed [19:0] lmsr_s2 [3];
	logic [37:0]        sq_s3   [3];
	logic signed [19:0] lmsr_s3 [3];
	logic signed [39:0] plo_s4  [3];
	logic signed [39:0] phi_s4  [3];
	logic signed [24:0] lms_s5  [3];
	logic signed [44:0] rp_s6   [3][3];
	logic signed [27:0] lin_s7  [3];
	logic [NW-1:0]      xc_s8   [3];
	logic               clip_s8;
	logic [NW-1:0]      xc_s9   [3];
	logic [7:0]         code_s9 [3];
	logic               clip_s9;
	logic [7:0]         code_s10 [3];
	logic               clip_s10;

	logic signed [39:0] lsum [3];
	logic signed [57:0] cube [3];
	logic signed [46:0] rsum [3];
	logic [NW-1:0]      xc   [3];
	logic [2:0]         clip_ch;
	logic [7:0]         hi_code [3];
	logic [7:0]         lo_code [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = 40'(lp_s1[i][0]) + 40'(lp_s1[i][1]) + 40'(lp_s1[i][2]) + 40'sd32768;
			cube[i] = (58'(phi_s4[i]) <<< 19) + 58'(plo_s4[i]) + 58'sd2147483648;
			rsum[i] = 47'(rp_s6[i][0]) + 47'(rp_s6[i][1]) + 47'(rp_s6[i][2]) + 47'sd32768;
			clip_ch[i] = (lin_s7[i] < 0) || (lin_s7[i] > 28'sd65536);
			if (lin_s7[i] < 0)
				xc[i] = '0;
			else if (lin_s7[i] > 28'sd65536)
				xc[i] = NW'(65536);
			else
				xc[i] = lin_s7[i][NW-1:0];
		end
	end

	// Binary search over the monotonic midpoint table, four bits per stage.
	always_comb begin
		logic [7:0] cand;
		for (int i = 0; i < 3; i++) begin
			hi_code[i] = '0;
			for (int bt = 7; bt >= 4; bt--) begin
				cand = hi_code[i] | (8'd1 << bt);
				if (xc_s8[i] >= opa_pkg::ENC_THR[cand])
					hi_code[i] = cand;
			end
			lo_code[i] = code_s9[i];
			for (int bt = 3; bt >= 0; bt--) begin
				cand = lo_code[i] | (8'd1 << bt);
				if (xc_s9[i] >= opa_pkg::ENC_THR[cand])
					lo_code[i] = cand;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					lp_s1[i][j] <= opa_pkg::INV_LMS[i][j] * lab[j];
					rp_s6[i][j] <= opa_pkg::INV_RGB[i][j] * lms_s5[j];
				end
				lmsr_s2[i] <= lsum[i][35:16];
				sq_s3[i]   <= 38'(lmsr_s2[i] * lmsr_s2[i]);
				lmsr_s3[i] <= lmsr_s2[i];
				plo_s4[i]  <= $signed({1'b0, sq_s3[i][18:0]}) * lmsr_s3[i];
				phi_s4[i]  <= $signed({1'b0, sq_s3[i][37:19]}) * lmsr_s3[i];
				lms_s5[i]  <= cube[i][56:32];
				lin_s7[i]  <= rsum[i][43:16];
				xc_s8[i]   <= xc[i];
				xc_s9[i]   <= xc_s8[i];
				code_s9[i] <= hi_code[i];
				code_s10[i] <= lo_code[i];
			end
			clip_s8  <= |clip_ch;
			clip_s9  <= clip_s8;
			clip_s10 <= clip_s9;
		end
	end

	assign red     = code_s10[0];
	assign green   = code_s10[1];
	assign blue    = code_s10[2];
	assign clipped = clip_s10;
endmodule

`default_nettype wire

@@ src/oklab_pixel_adjuster_top.sv @@
// ----------------------------------------------------------------------------
// OKLab pixel adjuster
// Throughput: one pixel per cycle; the whole pipeline advances on one enable
// that is high unless the output register holds a result that is not taken.
// Reset: arst_n clears all valid bits and the configuration registers (mode
// lighter, factor zero, tint colour black); the data path is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oklab_pixel_adjuster_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	opa_pix_in_if.sink                           pixel,
	opa_pix_out_if.source                        result,
	input  logic                                 cfg_we,
	input  logic [opa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [opa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	localparam int LAT = opa_pkg::PIPE_LAT;

	// Configuration registers. Change them only while the pipeline is empty;
	// the block does not enforce this. The data path reads them directly.
	opa_pkg::mode_t                    mode_q;
	logic signed [opa_pkg::FAC_W-1:0]  factor_q;
	logic [opa_pkg::CH_W-1:0]          tint_red_q;
	logic [opa_pkg::CH_W-1:0]          tint_green_q;
	logic [opa_pkg::CH_W-1:0]          tint_blue_q;

	// One valid bit per pipeline stage; the last one is the output register.
	logic [LAT-1:0] vld_q;
	logic           en;

	logic signed [opa_pkg::LAB_W-1:0]  lab  [3];
	logic signed [opa_pkg::LAB_W-1:0]  tlab [3];
	logic signed [opa_pkg::LABC_W-1:0] lab_adj [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= opa_pkg::MODE_LIGHTER;
			factor_q     <= '0;
			tint_red_q   <= '0;
			tint_green_q <= '0;
			tint_blue_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				opa_pkg::CFG_MODE:       mode_q       <= opa_pkg::mode_t'(cfg_wdata[2:0]);
				opa_pkg::CFG_FACTOR:     factor_q     <= cfg_wdata;
				opa_pkg::CFG_TINT_RED:   tint_red_q   <= cfg_wdata[opa_pkg::CH_W-1:0];
				opa_pkg::CFG_TINT_GREEN: tint_green_q <= cfg_wdata[opa_pkg::CH_W-1:0];
				opa_pkg::CFG_TINT_BLUE:  tint_blue_q  <= cfg_wdata[opa_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is empty or being taken.
	// A new request is accepted in the same cycle, so a full pipeline streams
	// one pixel per clock.
	assign en          = !result.valid || result.ready;
	assign pixel.ready = en;
	assign result.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pixel.valid};
		end
	end

	// Pixel lane: sRGB to OKLab.
	opa_to_lab u_pix_lab (
		.clk   (clk),
		.en    (en),
		.red   (pixel.in_red),
		.green (pixel.in_green),
		.blue  (pixel.in_blue),
		.lab   (lab)
	);

	// Tint lane: the tint colour runs through an identical converter in step
	// with the pixel, so its Lab value is ready exactly when the pixel's is.
	opa_to_lab u_tint_lab (
		.clk   (clk),
		.en    (en),
		.red   (tint_red_q),
		.green (tint_green_q),
		.blue  (tint_blue_q),
		.lab   (tlab)
	);

	opa_adjust u_adjust (
		.clk     (clk),
		.en      (en),
		.mode    (mode_q),
		.factor  (factor_q),
		.lab     (lab),
		.tint_a  (tlab[1]),
		.tint_b  (tlab[2]),
		.lab_adj (lab_adj)
	);

	// Inverse path. Its final stage doubles as the output register.
	opa_to_rgb u_to_rgb (
		.clk     (clk),
		.en      (en),
		.lab     (lab_adj),
		.red     (result.out_red),
		.green   (result.out_green),
		.blue    (result.out_blue),
		.clipped (result.clipped)
	);

	// A held result must stop the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pixel.ready)
		else $error("input accepted while the output register is stalled");

	// An accepted request occupies the first stage on the next edge.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> vld_q[0])
		else $error("accepted pixel did not enter the pipeline");

	// A stall freezes every valid bit.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

	// A taken result with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !vld_q[LAT-2] |=> !result.valid)
		else $error("result repeated after it was taken");
endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// OKLab pixel adjuster testbench
// Sends sRGB pixel requests through every adjustment mode and several factor
// and tint settings, predicts each adjusted pixel in fixed point and compares
// every result request field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import opa_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       clipped;
	} pixel_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	opa_pix_in_if pixel ();
	opa_pix_out_if result ();

	oklab_pixel_adjuster_top uut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Our own copy of the configuration registers.
	logic [2:0] cur_mode;
	logic signed [15:0] cur_factor;
	logic [7:0] tint_r, tint_g, tint_b;

	// Decode curve and encode thresholds, worked out here from first principles.
	longint decode_lut [256];
	longint encode_thr [256];

	pixel_res_t adjusted_q[$];
	bit failed;
	bit idle_on;
	longint cycles;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic longint div_half_up(input longint p, input int n);
		longint q;
		q = p + (longint'(1) << (n - 1));
		return q >>> n;
	endfunction

	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unsigned fifth_pow(input longint unsigned r);
		longint unsigned p;
		p = (r * r) >> 24;
		p = (p * r) >> 24;
		p = (p * r) >> 24;
		return (p * r) >> 24;
	endfunction

	function automatic longint srgb_to_linear(input int c);
		longint unsigned t, lo, hi, mid, u, l24;
		if (c <= 10)
			return (longint'(c) * 6553600 + 164730) / 329460;
		t = ((longint'(c) * 1000 + 14025) << 24) / 269025;
		lo = 0;
		hi = 64'd1 << 24;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (fifth_pow(mid) <= t)
				lo = mid;
			else
				hi = mid - 1;
		end
		u = (t * lo) >> 24;
		l24 = (u * u) >> 24;
		return longint'((l24 + 128) >> 8);
	endfunction

	function automatic logic [7:0] linear_to_srgb(input longint x);
		int code;
		code = 0;
		for (int k = 1; k < 256; k++)
			if (x >= encode_thr[k])
				code++;
		return code[7:0];
	endfunction

	function automatic longint cube_root_q16(input longint x);
		longint unsigned tgt, lo, hi, mid, r2;
		x = clampl(x, 0, 65536);
		tgt = longint'(x) << 32;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid * mid <= tgt)
				lo = mid;
			else
				hi = mid - 1;
		end
		r2 = 2 * lo + 1;
		if (r2 * r2 * r2 <= (longint'(x) << 35))
			lo++;
		return longint'(lo);
	endfunction

	function automatic void mat_mul(input mat_t m, input longint v [3], output longint o [3]);
		for (int i = 0; i < 3; i++)
			o[i] = div_half_up(longint'(m[i][0]) * v[0] + longint'(m[i][1]) * v[1]
				+ longint'(m[i][2]) * v[2], 16);
	endfunction

	function automatic void srgb_to_oklab(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, output longint lab [3]);
		longint lin [3];
		longint lms [3];
		longint root [3];
		lin[0] = decode_lut[r];
		lin[1] = decode_lut[g];
		lin[2] = decode_lut[b];
		mat_mul(FWD_LMS, lin, lms);
		for (int i = 0; i < 3; i++)
			root[i] = cube_root_q16(lms[i]);
		mat_mul(FWD_LAB, root, lab);
	endfunction

	function automatic pixel_res_t adjust_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint lab [3];
		longint tl [3];
		longint lmsr [3];
		longint lms [3];
		longint lin [3];
		longint f;
		pixel_res_t res;
		f = longint'(cur_factor);
		srgb_to_oklab(r, g, b, lab);
		case (cur_mode)
			MODE_LIGHTER: lab[0] = clampl(div_half_up(lab[0] * (16384 + f), 14), 0, 65536);
			MODE_DARKER:  lab[0] = clampl(div_half_up(lab[0] * (16384 - f), 14), 0, 65536);
			MODE_SCALE:   lab[0] = clampl(div_half_up(lab[0] * f, 14), 0, 65536);
			MODE_TINT: begin
				srgb_to_oklab(tint_r, tint_g, tint_b, tl);
				lab[1] += div_half_up((tl[1] - lab[1]) * f, 14);
				lab[2] += div_half_up((tl[2] - lab[2]) * f, 14);
			end
			MODE_SAT: begin
				lab[1] = div_half_up(lab[1] * (16384 - f), 14);
				lab[2] = div_half_up(lab[2] * (16384 - f), 14);
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++)
			lab[i] = clampl(lab[i], -131072, 131071);
		mat_mul(INV_LMS, lab, lmsr);
		for (int i = 0; i < 3; i++)
			lms[i] = div_half_up(lmsr[i] * lmsr[i] * lmsr[i], 32);
		mat_mul(INV_RGB, lms, lin);
		res.clipped = 1'b0;
		for (int i = 0; i < 3; i++)
			if (lin[i] < 0 || lin[i] > 65536)
				res.clipped = 1'b1;
		res.red = linear_to_srgb(clampl(lin[0], 0, 65536));
		res.green = linear_to_srgb(clampl(lin[1], 0, 65536));
		res.blue = linear_to_srgb(clampl(lin[2], 0, 65536));
		return res;
	endfunction

	// Idling helper: true with a chance of about 34 in a hundred when enabled.
	function automatic bit take_break();
		return idle_on && ($urandom_range(99) < 34);
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODE:       cur_mode = val[2:0];
			CFG_FACTOR:     cur_factor = val;
			CFG_TINT_RED:   tint_r = val[7:0];
			CFG_TINT_GREEN: tint_g = val[7:0];
			CFG_TINT_BLUE:  tint_b = val[7:0];
			default: ;
		endcase
	endtask

	// Sends one pixel request; valid stays high across back-to-back requests.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (take_break()) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.in_red <= r;
		pixel.in_green <= g;
		pixel.in_blue <= b;
		adjusted_q.push_back(adjust_pixel(r, g, b));
		@(posedge clk);
		while (!pixel.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		pixel.valid <= 1'b0;
		while (adjusted_q.size() != 0)
			@(negedge clk);
		// The pipeline holds nothing else, but give it its latency anyway.
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic set_all(input mode_t m, input logic [15:0] f,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pause_sender();
		write_reg(CFG_MODE, 16'(m));
		write_reg(CFG_FACTOR, f);
		write_reg(CFG_TINT_RED, 16'(r));
		write_reg(CFG_TINT_GREEN, 16'(g));
		write_reg(CFG_TINT_BLUE, 16'(b));
	endtask

	// Directed pixels: channel extremes, primaries and the linear-segment
	// knee of the sRGB curve.
	task automatic test_directed();
		logic [7:0] vals [8];
		vals = '{8'd0, 8'd255, 8'd10, 8'd11, 8'd128, 8'd1, 8'd254, 8'd85};
		set_all(MODE_LIGHTER, 16'd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 8; i++)
			send_pixel(vals[i], vals[(i + 3) % 8], vals[(i + 5) % 8]);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
	endtask

	// Every mode code, defined or not, with a mid factor or a factor extreme in
	// turn; the extremes drive lightness out of range and push colours out of gamut.
	task automatic test_modes();
		logic [15:0] fac [4];
		fac = '{16'h2000, 16'h8000, 16'h7FFF, 16'hFFFF};
		for (int m = 0; m < 8; m++) begin
			set_all(mode_t'(m), fac[m % 4], 8'd255, 8'd32, 8'd200);
			send_pixel(8'd200, 8'd90, 8'd30);
			send_pixel(8'd255, 8'd255, 8'd255);
		end
	endtask

	// Random pixels in random settings; each phase keeps one setting.
	task automatic test_random(input int phases, input int per_phase);
		logic [15:0] f;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(3))
				0: f = 16'h0000;
				1: f = 16'h4000;
				2: f = 16'(16'sh1000 * $signed(4'($urandom_range(15))));
				default: f = 16'($urandom);
			endcase
			set_all(mode_t'($urandom_range(7)), f, 8'($urandom), 8'($urandom),
				8'($urandom));
			// A stretch without any idling in the middle phase.
			idle_on = (p != phases / 2);
			for (int i = 0; i < per_phase; i++)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			idle_on = 1'b1;
		end
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && result.valid && result.ready) begin
			if (adjusted_q.size() == 0) begin
				$error("result request with no pixel outstanding");
				failed = 1'b1;
			end else begin
				want = adjusted_q.pop_front();
				if (result.out_red !== want.red) begin
					$error("out_red expected %0d actual %0d", want.red, result.out_red);
					failed = 1'b1;
				end
				if (result.out_green !== want.green) begin
					$error("out_green expected %0d actual %0d", want.green, result.out_green);
					failed = 1'b1;
				end
				if (result.out_blue !== want.blue) begin
					$error("out_blue expected %0d actual %0d", want.blue, result.out_blue);
					failed = 1'b1;
				end
				if (result.clipped !== want.clipped) begin
					$error("clipped expected %0d actual %0d", want.clipped, result.clipped);
					failed = 1'b1;
				end
			end
		end
	end

	always @(negedge clk)
		result.ready <= !take_break();

	// Watchdog: several times the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("oklab_pixel_adjuster_top regression: fail");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		idle_on = 1'b1;
		cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pixel.valid = 1'b0;
		pixel.in_red = '0;
		pixel.in_green = '0;
		pixel.in_blue = '0;
		result.ready = 1'b0;
		cur_mode = '0;
		cur_factor = '0;
		tint_r = '0;
		tint_g = '0;
		tint_b = '0;
		for (int c = 0; c < 256; c++)
			decode_lut[c] = srgb_to_linear(c);
		encode_thr[0] = 0;
		for (int k = 1; k < 256; k++)
			encode_thr[k] = (decode_lut[k - 1] + decode_lut[k] + 1) >>> 1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_modes();
		test_random(20, 31);

		pixel.valid <= 1'b0;
		while (adjusted_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 8) @(negedge clk);
		if (!failed)
			$display("oklab_pixel_adjuster_top regression: pass");
		else
			$display("oklab_pixel_adjuster_top regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
src/opa_pkg.sv
src/opa_pix_in_if.sv
src/opa_pix_out_if.sv
src/opa_cbrt.sv
src/opa_to_lab.sv
src/opa_adjust.sv
src/opa_to_rgb.sv
src/oklab_pixel_adjuster_top.sv
tb/sv/testbench.sv
